>>> rtl/vaso_pkg.sv
// vaso_pkg: shared types and constants for the voice allocator
// no dependencies; used by vaso_ctrl, vaso_dp and the top level
package vaso_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = 5;
  localparam int CNT_W = 6;
  localparam int SMP_W = 16;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_TRIG  = 3'd0,
    KIND_REL   = 3'd1,
    KIND_BEGUN = 3'd2,
    KIND_DEACT = 3'd3,
    KIND_ACT   = 3'd4,
    KIND_EMPTY = 3'd5,
    KIND_ERR   = 3'd6
  } kind_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEGIN,
    OP_POP,
    OP_STEAL_INIT,
    OP_AGE_FIND,
    OP_AGE_SHIFT,
    OP_REL_DONE,
    OP_ERR,
    OP_ST_FIND,
    OP_ST_SHIFT,
    OP_SP_FIND,
    OP_STEAL_DONE,
    OP_EMPTY,
    OP_RPT_STOP,
    OP_RPT_START,
    OP_IDX_CLR
  } op_t;

  typedef struct packed {
    cmd_t             cmd;
    logic             free_zero;
    logic             out_free;
    logic             age_end;
    logic             age_match;
    logic             age_last;
    logic             st_end;
    logic             st_match;
    logic             st_last;
    logic             sp_end;
    logic             sp_last;
    logic             started_zero;
    logic             report_empty;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] age_cnt;
  } status_t;

endpackage

>>> rtl/vaso_ctrl.sv
// vaso_ctrl: sequencing state machine of the voice allocator
// depends on vaso_pkg; drives vaso_dp through one op per cycle
module vaso_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vaso_pkg::status_t st,
  output vaso_pkg::op_t     op
);

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_DISPATCH   = 16'h0002,
    S_BEGIN      = 16'h0004,
    S_POP        = 16'h0008,
    S_STEAL_INIT = 16'h0010,
    S_AGE_FIND   = 16'h0020,
    S_AGE_SHIFT  = 16'h0040,
    S_ST_FIND    = 16'h0080,
    S_ST_SHIFT   = 16'h0100,
    S_SP_FIND    = 16'h0200,
    S_STEAL_DONE = 16'h0400,
    S_REL_DONE   = 16'h0800,
    S_ERR        = 16'h1000,
    S_EMPTY      = 16'h2000,
    S_RPT_STOP   = 16'h4000,
    S_RPT_START  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = vaso_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = vaso_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.cmd)
          vaso_pkg::CMD_BEGIN:   state_nxt = S_BEGIN;
          vaso_pkg::CMD_TRIGGER: state_nxt = st.free_zero ? S_STEAL_INIT : S_POP;
          vaso_pkg::CMD_RELEASE: state_nxt = S_AGE_FIND;
          vaso_pkg::CMD_REPORT:  state_nxt = st.report_empty ? S_EMPTY : S_RPT_STOP;
          default:               state_nxt = S_IDLE;
        endcase
      end
      S_BEGIN: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_BEGIN;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_POP;
          state_nxt = S_IDLE;
        end
      end
      S_STEAL_INIT: begin
        if (st.age_end) begin
          state_nxt = S_ERR;
        end else begin
          op        = vaso_pkg::OP_STEAL_INIT;
          state_nxt = S_AGE_SHIFT;
        end
      end
      S_AGE_FIND: begin
        if (st.age_end) begin
          op        = vaso_pkg::OP_IDX_CLR;
          state_nxt = S_ERR;
        end else if (st.age_match) begin
          state_nxt = S_AGE_SHIFT;
        end else begin
          op = vaso_pkg::OP_AGE_FIND;
        end
      end
      S_AGE_SHIFT: begin
        op = vaso_pkg::OP_AGE_SHIFT;
        if (st.age_last) begin
          state_nxt = (st.cmd == vaso_pkg::CMD_RELEASE) ? S_REL_DONE : S_ST_FIND;
        end
      end
      S_ST_FIND: begin
        op = vaso_pkg::OP_ST_FIND;
        if (st.st_end) begin
          state_nxt = S_SP_FIND;
        end else if (st.st_match) begin
          state_nxt = S_ST_SHIFT;
        end
      end
      S_ST_SHIFT: begin
        op = vaso_pkg::OP_ST_SHIFT;
        if (st.st_last) begin
          state_nxt = S_SP_FIND;
        end
      end
      S_SP_FIND: begin
        op = vaso_pkg::OP_SP_FIND;
        if (st.sp_end) begin
          state_nxt = S_STEAL_DONE;
        end
      end
      S_STEAL_DONE: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_STEAL_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_REL_DONE: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_REL_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_ERR;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          op        = vaso_pkg::OP_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_RPT_STOP: begin
        if (st.sp_end) begin
          op        = vaso_pkg::OP_IDX_CLR;
          state_nxt = S_RPT_START;
        end else if (st.out_free) begin
          op = vaso_pkg::OP_RPT_STOP;
          if (st.sp_last && st.started_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RPT_START: begin
        if (st.out_free) begin
          op = vaso_pkg::OP_RPT_START;
          if (st.st_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/vaso_dp.sv
// vaso_dp: voice lists, counts, scan index and result register
// depends on vaso_pkg; executes the op chosen by vaso_ctrl
module vaso_dp #(
  parameter int MAX_VOICES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vaso_pkg::op_t                  op,
  output vaso_pkg::status_t              st,
  input  logic [1:0]                     in_cmd,
  input  logic [vaso_pkg::IDX_W-1:0]     in_voice,
  input  logic [vaso_pkg::SMP_W-1:0]     in_sample_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_kind,
  output logic [vaso_pkg::IDX_W-1:0]     out_voice_out,
  output logic [vaso_pkg::SMP_W-1:0]     out_sample_out,
  output logic                           out_stole,
  output logic [vaso_pkg::IDX_W-1:0]     out_stolen_voice,
  output logic                           out_last
);

  localparam int IW = vaso_pkg::IDX_W;
  localparam int CW = vaso_pkg::CNT_W;
  localparam int SW = vaso_pkg::SMP_W;
  localparam int D  = vaso_pkg::DEPTH;

  logic [IW-1:0]    free_stack_r   [D];
  logic [IW-1:0]    age_list_r     [D];
  logic [IW+SW-1:0] started_list_r [D];
  logic [IW-1:0]    stopped_list_r [D];

  logic [CW-1:0] free_cnt_r, age_cnt_r, st_cnt_r, sp_cnt_r, idx_r;
  logic          out_valid_r;
  vaso_pkg::cmd_t cmd_r;
  logic [IW-1:0] voice_r, sv_r;
  logic [SW-1:0] samp_r;
  logic          seen_r;

  logic [2:0]    kind_r;
  logic [IW-1:0] vout_r, svout_r;
  logic [SW-1:0] sout_r;
  logic          stole_r, last_r;

  logic [IW-1:0] ix, ix1, pop_v;
  logic [CW:0]   idx_p1;
  logic          emit, free_has_room;

  assign ix     = idx_r[IW-1:0];
  assign ix1    = ix + IW'(1);
  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign pop_v  = free_stack_r[IW'(free_cnt_r - CW'(1))];
  assign free_has_room = (free_cnt_r < CW'(D)) && (free_cnt_r < CW'(MAX_VOICES));

  always_comb begin
    st.cmd          = cmd_r;
    st.free_zero    = (free_cnt_r == '0);
    st.out_free     = !out_valid_r || !out_stall;
    st.age_end      = (idx_r >= age_cnt_r);
    st.age_match    = (age_list_r[ix] == voice_r);
    st.age_last     = (idx_p1 >= {1'b0, age_cnt_r});
    st.st_end       = (idx_r >= st_cnt_r);
    st.st_match     = (started_list_r[ix][IW+SW-1:SW] == sv_r);
    st.st_last      = (idx_p1 >= {1'b0, st_cnt_r});
    st.sp_end       = (idx_r >= sp_cnt_r);
    st.sp_last      = (idx_p1 >= {1'b0, sp_cnt_r});
    st.started_zero = (st_cnt_r == '0);
    st.report_empty = (st_cnt_r == '0) && (sp_cnt_r == '0);
    st.free_cnt     = free_cnt_r;
    st.age_cnt      = age_cnt_r;
  end

  always_comb begin
    case (op)
      vaso_pkg::OP_BEGIN, vaso_pkg::OP_POP, vaso_pkg::OP_REL_DONE, vaso_pkg::OP_ERR,
      vaso_pkg::OP_STEAL_DONE, vaso_pkg::OP_EMPTY, vaso_pkg::OP_RPT_STOP,
      vaso_pkg::OP_RPT_START: emit = 1'b1;
      default:                emit = 1'b0;
    endcase
  end

  // counts, index, free stack and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        free_stack_r[i] <= IW'(MAX_VOICES - 1 - i);
      end
      free_cnt_r  <= CW'(MAX_VOICES);
      age_cnt_r   <= '0;
      st_cnt_r    <= '0;
      sp_cnt_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && out_stall);
      case (op)
        vaso_pkg::OP_LOAD, vaso_pkg::OP_IDX_CLR: idx_r <= '0;
        vaso_pkg::OP_BEGIN: begin
          st_cnt_r <= '0;
          sp_cnt_r <= '0;
        end
        vaso_pkg::OP_POP: begin
          free_cnt_r <= free_cnt_r - CW'(1);
          if (st_cnt_r < CW'(D)) st_cnt_r <= st_cnt_r + CW'(1);
          if (age_cnt_r < CW'(D)) age_cnt_r <= age_cnt_r + CW'(1);
        end
        vaso_pkg::OP_AGE_FIND: idx_r <= idx_r + CW'(1);
        vaso_pkg::OP_AGE_SHIFT: begin
          if (st.age_last) begin
            age_cnt_r <= age_cnt_r - CW'(1);
            idx_r     <= '0;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        vaso_pkg::OP_REL_DONE: begin
          if (free_has_room) begin
            free_stack_r[IW'(free_cnt_r)] <= voice_r;
            free_cnt_r <= free_cnt_r + CW'(1);
          end
        end
        vaso_pkg::OP_ST_FIND: begin
          if (st.st_end) idx_r <= '0;
          else if (!st.st_match) idx_r <= idx_r + CW'(1);
        end
        vaso_pkg::OP_ST_SHIFT: begin
          if (st.st_last) begin
            st_cnt_r <= st_cnt_r - CW'(1);
            idx_r    <= '0;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        vaso_pkg::OP_SP_FIND: begin
          if (st.sp_end) idx_r <= '0;
          else idx_r <= idx_r + CW'(1);
        end
        vaso_pkg::OP_STEAL_DONE: begin
          if (!seen_r && sp_cnt_r < CW'(D)) sp_cnt_r <= sp_cnt_r + CW'(1);
          if (st_cnt_r < CW'(D)) st_cnt_r <= st_cnt_r + CW'(1);
          if (age_cnt_r < CW'(D)) age_cnt_r <= age_cnt_r + CW'(1);
        end
        vaso_pkg::OP_RPT_STOP, vaso_pkg::OP_RPT_START: idx_r <= idx_r + CW'(1);
        default: ;
      endcase
    end
  end

  // list storage, item registers and result payload
  always_ff @(posedge clk) begin
    case (op)
      vaso_pkg::OP_LOAD: begin
        cmd_r   <= vaso_pkg::cmd_t'(in_cmd);
        voice_r <= in_voice;
        samp_r  <= in_sample_index;
      end
      vaso_pkg::OP_POP: begin
        if (st_cnt_r < CW'(D)) started_list_r[IW'(st_cnt_r)] <= {pop_v, samp_r};
        if (age_cnt_r < CW'(D)) age_list_r[IW'(age_cnt_r)] <= pop_v;
      end
      vaso_pkg::OP_STEAL_INIT: begin
        sv_r   <= age_list_r[0];
        seen_r <= 1'b0;
      end
      vaso_pkg::OP_AGE_SHIFT: begin
        if (!st.age_last) age_list_r[ix] <= age_list_r[ix1];
      end
      vaso_pkg::OP_ST_SHIFT: begin
        if (!st.st_last) started_list_r[ix] <= started_list_r[ix1];
      end
      vaso_pkg::OP_SP_FIND: begin
        if (!st.sp_end && stopped_list_r[ix] == sv_r) seen_r <= 1'b1;
      end
      vaso_pkg::OP_STEAL_DONE: begin
        if (!seen_r && sp_cnt_r < CW'(D)) stopped_list_r[IW'(sp_cnt_r)] <= sv_r;
        if (st_cnt_r < CW'(D)) started_list_r[IW'(st_cnt_r)] <= {sv_r, samp_r};
        if (age_cnt_r < CW'(D)) age_list_r[IW'(age_cnt_r)] <= sv_r;
      end
      default: ;
    endcase

    if (emit) begin
      vout_r  <= '0;
      sout_r  <= '0;
      stole_r <= 1'b0;
      svout_r <= '0;
      last_r  <= 1'b1;
      case (op)
        vaso_pkg::OP_BEGIN: kind_r <= vaso_pkg::KIND_BEGUN;
        vaso_pkg::OP_POP: begin
          kind_r <= vaso_pkg::KIND_TRIG;
          vout_r <= pop_v;
        end
        vaso_pkg::OP_STEAL_DONE: begin
          kind_r  <= vaso_pkg::KIND_TRIG;
          vout_r  <= sv_r;
          stole_r <= 1'b1;
          svout_r <= sv_r;
        end
        vaso_pkg::OP_REL_DONE: begin
          kind_r <= vaso_pkg::KIND_REL;
          vout_r <= voice_r;
        end
        vaso_pkg::OP_ERR: begin
          kind_r <= vaso_pkg::KIND_ERR;
          vout_r <= (cmd_r == vaso_pkg::CMD_RELEASE) ? voice_r : '0;
        end
        vaso_pkg::OP_RPT_STOP: begin
          kind_r <= vaso_pkg::KIND_DEACT;
          vout_r <= stopped_list_r[ix];
          last_r <= st.sp_last && st.started_zero;
        end
        vaso_pkg::OP_RPT_START: begin
          kind_r <= vaso_pkg::KIND_ACT;
          vout_r <= started_list_r[ix][IW+SW-1:SW];
          sout_r <= started_list_r[ix][SW-1:0];
          last_r <= st.st_last;
        end
        default: kind_r <= vaso_pkg::KIND_EMPTY;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_voice_out    = vout_r;
  assign out_sample_out   = sout_r;
  assign out_stole        = stole_r;
  assign out_stolen_voice = svout_r;
  assign out_last         = last_r;

endmodule

>>> rtl/voice_allocator_steal_oldest_core.sv
// voice_allocator_steal_oldest_core: top level of the voice allocator
// depends on vaso_pkg, vaso_ctrl and vaso_dp
//
// One item is worked at a time. in_stall is high from acceptance until the item's
// last result is loaded into the output register. A release, found or not, scans
// the age list. A trigger that steals walks the age, started and stopped lists one
// entry a cycle. A report emits one entry a cycle as the output side takes them,
// with an index-clearing step between the deactivated and the activated entries.
// All scans run through one shared index register. No clearing pass after reset.
module voice_allocator_steal_oldest_core #(
  parameter int MAX_VOICES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_voice,
  input  logic [15:0] in_sample_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_voice_out,
  output logic [15:0] out_sample_out,
  output logic        out_stole,
  output logic [4:0]  out_stolen_voice,
  output logic        out_last
);

  vaso_pkg::op_t     op;
  vaso_pkg::status_t st;

  vaso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  vaso_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .st               (st),
    .in_cmd           (in_cmd),
    .in_voice         (in_voice),
    .in_sample_index  (in_sample_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_voice_out    (out_voice_out),
    .out_sample_out   (out_sample_out),
    .out_stole        (out_stole),
    .out_stolen_voice (out_stolen_voice),
    .out_last         (out_last)
  );

  // every voice is either free or active between items
  a_voice_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> ({1'b0, st.free_cnt} + {1'b0, st.age_cnt}) == 7'(MAX_VOICES))
    else $error("free and active voice counts do not add up");

  // an accepted item keeps the input side closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item accepted");

  // a trigger result that stole names the same voice twice
  a_steal_voice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stole) |-> (out_voice_out == out_stolen_voice))
    else $error("stolen voice differs from allocated voice");

endmodule
